// ===== hdl/fsctu_pkg.sv =====
package fsctu_pkg;

   // Request modes.
   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_RANK  = 2'd1;
   localparam logic [1:0] MODE_SLOT  = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam int RANK_W = 5;
   localparam int USED_W = 6;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]          mode;
      logic signed [31:0]  in_value;
      logic [4:0]          read_index;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  out_value;
      logic [31:0]         out_count;
      logic [RANK_W-1:0]   out_rank;
      logic                entry_valid;
      logic                dropped;
      logic [USED_W-1:0]   distinct_used;
      logic [31:0]         total_adds;
   } rsp_type;

   // One table entry as held in a cell.
   typedef struct packed {
      logic signed [31:0]  value;
      logic [31:0]         count;
   } entry_type;

   // Broadcast from the control to every cell.
   typedef struct packed {
      logic                capture;
      logic [1:0]          op;
      logic signed [31:0]  key;
      logic [4:0]          read_index;
      logic                update;
      logic                do_shift;
      logic                do_append;
      logic signed [31:0]  new_value;
      logic [31:0]         new_count;
   } cmd_type;

   // Per-cell status back to the control and to the next cell.
   typedef struct packed {
      logic match;
      logic lt;
      logic target;
   } cell_stat_type;

endpackage

// ===== hdl/fsctu_cell.sv =====
module fsctu_cell #(
   parameter int CELL_INDEX = 0,
   parameter int SLOT_W     = 5,
   parameter int DIST_W     = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fsctu_pkg::cmd_type        cmd,
   input  logic [DIST_W-1:0]         distinct,
   input  logic [SLOT_W-1:0]         cur_rank,
   input  logic [SLOT_W-1:0]         hit_slot,
   input  fsctu_pkg::entry_type      prev_entry,
   input  logic [SLOT_W-1:0]         prev_slot,
   input  logic                      prev_lt,
   output fsctu_pkg::entry_type      entry,
   output logic [SLOT_W-1:0]         slot,
   output fsctu_pkg::cell_stat_type  stat
);
   import fsctu_pkg::*;

   entry_type            entry_ff, entry_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 match_ff, match_in;
   logic                 held, lt, take, target;

   // The cell holds an entry when its rank is below the fill level.
   assign held = CELL_INDEX < int'(distinct);

   always_comb begin
      case (cmd.op)
         MODE_ADD:  match_in = held && (entry_ff.value == cmd.key);
         MODE_RANK: match_in = held && (CELL_INDEX == int'(cmd.read_index));
         MODE_SLOT: match_in = held && (int'(slot_ff) == int'(cmd.read_index));
         default:   match_in = 1'b0;
      endcase
   end

   // An entry ranked above the hit one whose count is now smaller moves down one place.
   assign lt     = held && (CELL_INDEX < int'(cur_rank)) && (entry_ff.count < cmd.new_count);
   assign take   = cmd.do_shift && (lt || match_ff);
   assign target = take && !prev_lt;

   always_comb begin
      entry_in = entry_ff;
      slot_in  = slot_ff;
      if (cmd.update) begin
         if (cmd.do_append && (CELL_INDEX == int'(distinct))) begin
            entry_in.value = cmd.new_value;
            entry_in.count = 32'd1;
            slot_in        = SLOT_W'(CELL_INDEX);
         end else if (take) begin
            if (prev_lt) begin
               entry_in = prev_entry;
               slot_in  = prev_slot;
            end else begin
               entry_in.value = cmd.new_value;
               entry_in.count = cmd.new_count;
               slot_in        = hit_slot;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      slot_ff  <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (cmd.capture) begin
         match_ff <= match_in;
      end
   end

   assign entry       = entry_ff;
   assign slot        = slot_ff;
   assign stat.match  = match_ff;
   assign stat.lt     = lt;
   assign stat.target = target;

endmodule

// ===== hdl/frequency_sorted_count_table_unit.sv =====
// Channel   Ports                      Direction  Handshake
// request   start, busy, req_data      in         beat taken when start is high, busy low
// response  rsp_strobe, rsp_data       out        beat shown for one cycle under rsp_strobe
//
// Each request runs as follows: the accepting edge registers the match result
// of every cell, and the next edge applies the update and registers the response,
// which is shown in the cycle after that. A new request is taken in that same
// cycle, so the block takes no new request while one is in flight; the pace is set by
// the match stage and the one-position shift through the row of cells.
// Reset is synchronous and active high and empties the table; no clearing pass
// is needed. The receiver cannot stall the response, so nothing ever backs up.
module frequency_sorted_count_table_unit #(
   parameter int ENTRIES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fsctu_pkg::req_type   req_data,
   output logic                 rsp_strobe,
   output fsctu_pkg::rsp_type   rsp_data
);
   import fsctu_pkg::*;

   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int DIST_W = $clog2(ENTRIES + 1);

   // Control and result registers.
   logic                busy_ff;
   req_type             req_ff;
   logic [DIST_W-1:0]   distinct_ff, distinct_in;
   logic [31:0]         total_ff, total_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_strobe_ff;

   // The row of cells, held in rank order: cell zero has the highest count.
   entry_type           cell_entry [ENTRIES];
   logic [SLOT_W-1:0]   cell_slot  [ENTRIES];
   cell_stat_type       cell_stat  [ENTRIES];
   entry_type           prev_entry [ENTRIES];
   logic [SLOT_W-1:0]   prev_slot  [ENTRIES];
   logic                prev_lt    [ENTRIES];

   cmd_type             cmd;
   logic                capture;
   logic                any_match;
   logic                full;
   logic signed [31:0]  sel_value;
   logic [31:0]         sel_count;
   logic [SLOT_W-1:0]   sel_slot;
   logic [SLOT_W-1:0]   cur_rank;
   logic [SLOT_W-1:0]   new_rank;
   logic [31:0]         new_count;
   logic [31:0]         total_inc;

   assign capture = start && !busy_ff;
   assign full    = distinct_ff == DIST_W'(ENTRIES);

   // At most one cell matches, so the selected entry is an OR over the row.
   always_comb begin
      any_match = 1'b0;
      sel_value = '0;
      sel_count = '0;
      sel_slot  = '0;
      cur_rank  = '0;
      new_rank  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cell_stat[i].match) begin
            any_match = 1'b1;
            sel_value = sel_value | cell_entry[i].value;
            sel_count = sel_count | cell_entry[i].count;
            sel_slot  = sel_slot | cell_slot[i];
            cur_rank  = cur_rank | SLOT_W'(i);
         end
         if (cell_stat[i].target) begin
            new_rank = new_rank | SLOT_W'(i);
         end
      end
   end

   // Counts saturate at their maximum.
   assign new_count = (sel_count == COUNT_MAX) ? sel_count : sel_count + 32'd1;
   assign total_inc = (total_ff == COUNT_MAX) ? total_ff : total_ff + 32'd1;

   always_comb begin
      cmd.capture    = capture;
      cmd.op         = req_data.mode;
      cmd.key        = req_data.in_value;
      cmd.read_index = req_data.read_index;
      cmd.update     = busy_ff;
      cmd.do_shift   = busy_ff && (req_ff.mode == MODE_ADD) && any_match;
      cmd.do_append  = busy_ff && (req_ff.mode == MODE_ADD) && !any_match && !full;
      cmd.new_value  = req_ff.in_value;
      cmd.new_count  = new_count;
   end

   // Each cell looks only at its upper neighbour; the top cell has none.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_row
      if (g == 0) begin : g_head
         assign prev_entry[g] = '0;
         assign prev_slot[g]  = '0;
         assign prev_lt[g]    = 1'b0;
      end else begin : g_link
         assign prev_entry[g] = cell_entry[g-1];
         assign prev_slot[g]  = cell_slot[g-1];
         assign prev_lt[g]    = cell_stat[g-1].lt;
      end

      fsctu_cell #(
         .CELL_INDEX (g),
         .SLOT_W     (SLOT_W),
         .DIST_W     (DIST_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .distinct   (distinct_ff),
         .cur_rank   (cur_rank),
         .hit_slot   (sel_slot),
         .prev_entry (prev_entry[g]),
         .prev_slot  (prev_slot[g]),
         .prev_lt    (prev_lt[g]),
         .entry      (cell_entry[g]),
         .slot       (cell_slot[g]),
         .stat       (cell_stat[g])
      );
   end

   // Response and totals, worked out in the update cycle.
   always_comb begin
      distinct_in = distinct_ff;
      total_in    = total_ff;
      rsp_in      = '0;
      case (req_ff.mode)
         MODE_ADD: begin
            total_in         = total_inc;
            rsp_in.out_value = req_ff.in_value;
            if (any_match) begin
               // A known value: raised count, new rank after the shift.
               rsp_in.out_count   = new_count;
               rsp_in.out_rank    = RANK_W'(new_rank);
               rsp_in.entry_valid = 1'b1;
            end else if (full) begin
               rsp_in.dropped = 1'b1;
            end else begin
               // A new value joins at the lowest rank.
               rsp_in.out_count   = 32'd1;
               rsp_in.out_rank    = RANK_W'(distinct_ff);
               rsp_in.entry_valid = 1'b1;
               distinct_in        = distinct_ff + DIST_W'(1);
            end
         end
         MODE_RANK, MODE_SLOT: begin
            if (any_match) begin
               rsp_in.out_value   = sel_value;
               rsp_in.out_count   = sel_count;
               rsp_in.out_rank    = RANK_W'(cur_rank);
               rsp_in.entry_valid = 1'b1;
            end
         end
         MODE_CLEAR: begin
            distinct_in = '0;
            total_in    = '0;
         end
         default: begin
         end
      endcase
      rsp_in.distinct_used = USED_W'(distinct_in);
      rsp_in.total_adds    = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         distinct_ff   <= '0;
         total_ff      <= '0;
      end else begin
         busy_ff       <= capture;
         rsp_strobe_ff <= busy_ff;
         if (busy_ff) begin
            distinct_ff <= distinct_in;
            total_ff    <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         req_ff <= req_data;
      end
      if (busy_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import fsctu_pkg::*;

   // The table size of the instance, which the predictor below mirrors.
   localparam int ENTRIES       = 32;
   // Random request beats that follow the directed plan.
   localparam int RANDOM_BEATS  = 1900;
   // Cycles without any handshake after which the run is declared hung.
   localparam int STALL_LIMIT   = 5000;
   // Quiet cycles at the end, to catch any response beat that should not come.
   localparam int DRAIN_CYCLES  = 8;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // A directed row may carry a typed-in response. It travels with the request
   // beat, driven on the same edge, so that the monitor sees both together.
   logic    row_has_rsp;
   rsp_type row_rsp;

   frequency_sorted_count_table_unit #(
      .ENTRIES(ENTRIES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor. The table is kept as insertion slots (value and count) plus
   // a rank list that maps each rank to its slot, highest count first.
   // ---------------------------------------------------------------------
   logic [31:0] tab_value [ENTRIES];
   logic [31:0] tab_count [ENTRIES];
   int          rank_slot [ENTRIES];
   int          held_n;
   logic [31:0] adds_total;

   function automatic void table_clear();
      int i;
      for (i = 0; i < ENTRIES; i++) begin
         tab_value[i] = '0;
         tab_count[i] = '0;
         rank_slot[i] = 0;
      end
      held_n     = 0;
      adds_total = '0;
   endfunction

   function automatic int rank_of_slot(int slot);
      int r;
      for (r = 0; r < held_n; r++)
         if (rank_slot[r] == slot)
            return r;
      return 0;
   endfunction

   // Applies one request to the predicted table and returns the response beat
   // that it should produce.
   function automatic rsp_type count_table_step(req_type rq);
      rsp_type     o;
      int          s;
      int          slot;
      int          cur;
      int          nr;
      int          r;
      bit          hit;
      logic [31:0] cnt;
      o    = '0;
      hit  = 1'b0;
      slot = 0;
      case (rq.mode)
         MODE_ADD: begin
            for (s = 0; s < held_n; s++)
               if (!hit && tab_value[s] == rq.in_value) begin
                  hit  = 1'b1;
                  slot = s;
               end
            if (adds_total != COUNT_MAX)
               adds_total = adds_total + 1;
            o.out_value = rq.in_value;
            if (!hit) begin
               // A new value either takes the next slot at the lowest rank, or
               // is dropped when every slot is taken.
               if (held_n >= ENTRIES) begin
                  o.dropped = 1'b1;
               end else begin
                  tab_value[held_n] = rq.in_value;
                  tab_count[held_n] = 32'd1;
                  rank_slot[held_n] = held_n;
                  o.out_count       = 32'd1;
                  o.out_rank        = RANK_W'(held_n);
                  o.entry_valid     = 1'b1;
                  held_n            = held_n + 1;
               end
            end else begin
               // A known value moves ahead of every entry above it whose count
               // is now smaller; a saturated count does not move at all.
               cur = rank_of_slot(slot);
               cnt = tab_count[slot];
               if (cnt != COUNT_MAX)
                  cnt = cnt + 1;
               tab_count[slot] = cnt;
               nr = cur;
               while (nr > 0 && tab_count[rank_slot[nr - 1]] < cnt)
                  nr--;
               for (r = cur; r > nr; r--)
                  rank_slot[r] = rank_slot[r - 1];
               rank_slot[nr] = slot;
               o.out_count   = cnt;
               o.out_rank    = RANK_W'(nr);
               o.entry_valid = 1'b1;
            end
         end
         MODE_CLEAR: begin
            table_clear();
         end
         default: begin
            if (int'(rq.read_index) < held_n) begin
               if (rq.mode == MODE_RANK) begin
                  slot       = rank_slot[rq.read_index];
                  o.out_rank = rq.read_index;
               end else begin
                  slot       = int'(rq.read_index);
                  o.out_rank = RANK_W'(rank_of_slot(slot));
               end
               o.out_value   = tab_value[slot];
               o.out_count   = tab_count[slot];
               o.entry_valid = 1'b1;
            end
         end
      endcase
      o.distinct_used = USED_W'(held_n);
      o.total_adds    = adds_total;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor and scoreboard. Both handshakes are sampled at the rising edge,
   // where every signal still holds the value of the cycle that ends there.
   // ---------------------------------------------------------------------
   rsp_type pending_rsp [$];
   rsp_type got_rsp;
   rsp_type want_rsp;
   rsp_type predicted;
   int      fail_count = 0;
   int      quiet_cycles = 0;

   task automatic report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%08h, expected 0x%08h", name, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         table_clear();
         pending_rsp.delete();
         quiet_cycles <= 0;
      end else begin
         // The response beat belongs to an earlier request, so it is matched
         // before a request accepted at this same edge adds its expectation.
         if (rsp_strobe) begin
            got_rsp = rsp_data;
            if (pending_rsp.size() == 0) begin
               report_mismatch("response beat with nothing outstanding");
            end else begin
               want_rsp = pending_rsp.pop_front();
               check_field("out_value", got_rsp.out_value, want_rsp.out_value);
               check_field("out_count", got_rsp.out_count, want_rsp.out_count);
               check_field("out_rank", 32'(got_rsp.out_rank), 32'(want_rsp.out_rank));
               check_field("entry_valid", 32'(got_rsp.entry_valid),
                           32'(want_rsp.entry_valid));
               check_field("dropped", 32'(got_rsp.dropped), 32'(want_rsp.dropped));
               check_field("distinct_used", 32'(got_rsp.distinct_used),
                           32'(want_rsp.distinct_used));
               check_field("total_adds", got_rsp.total_adds, want_rsp.total_adds);
            end
         end
         // The predictor always runs, so that its table stays in step; a
         // typed-in response, where the row has one, takes its place.
         if (start && !busy) begin
            predicted = count_table_step(req_data);
            pending_rsp.push_back(row_has_rsp ? row_rsp : predicted);
         end
         // Watchdog: any handshake counts as progress.
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------
   typedef struct {
      req_type rq;
      int      reps;
      bit      has_rsp;
      rsp_type rsp;
   } stim_row_type;

   stim_row_type plan [$];
   bit           gaps_on;
   int           beats_sent = 0;

   function automatic rsp_type rsp_of(logic [31:0] v, logic [31:0] c, int rk, bit vld,
                                      bit drp, int used, logic [31:0] tot);
      rsp_type o;
      o.out_value     = v;
      o.out_count     = c;
      o.out_rank      = RANK_W'(rk);
      o.entry_valid   = vld;
      o.dropped       = drp;
      o.distinct_used = USED_W'(used);
      o.total_adds    = tot;
      return o;
   endfunction

   // A row with several repeats adds consecutive values, starting at in_value.
   function automatic void push_row(logic [1:0] mode, logic [31:0] v, int idx, int reps,
                                    bit has_rsp, rsp_type rsp);
      stim_row_type row;
      row.rq.mode       = mode;
      row.rq.in_value   = v;
      row.rq.read_index = idx[4:0];
      row.reps          = reps;
      row.has_rsp       = has_rsp;
      row.rsp           = rsp;
      plan.push_back(row);
   endfunction

   // Presents one request beat and holds it until the block takes it. Start
   // is only raised here and only lowered by an idle gap or the wind down, so
   // it never gets two assignments in one time step.
   task automatic send_beat(req_type rq, bit has_rsp, rsp_type rsp);
      start       <= 1'b1;
      req_data    <= rq;
      row_has_rsp <= has_rsp;
      row_rsp     <= rsp;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      beats_sent++;
   endtask

   // Optional idle gap after a beat: mostly none or short, a few long. The
   // request bus carries junk while start is low.
   task automatic idle_gap();
      int      roll;
      int      len;
      req_type junk;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 60)
         return;
      len = (roll < 90) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      junk.mode       = 2'($urandom);
      junk.in_value   = $urandom;
      junk.read_index = 5'($urandom);
      start       <= 1'b0;
      req_data    <= junk;
      row_has_rsp <= 1'b0;
      repeat (len) @(posedge clock);
   endtask

   initial begin
      req_type     rq;
      rsp_type     none;
      logic [31:0] pool [64];
      int          pool_n;
      int          ep_len;
      int          roll;
      int          pick;
      int          i;
      int          k;

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      row_has_rsp = 1'b0;
      row_rsp     = '0;
      none        = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: an empty table, the value extremes, a reorder, reads
      // inside and beyond the held entries, clear, and a full table.
      push_row(MODE_RANK, 32'h0, 0, 1, 1, rsp_of(0, 0, 0, 0, 0, 0, 0));
      push_row(MODE_SLOT, 32'hFFFF_FFFF, 31, 1, 1, rsp_of(0, 0, 0, 0, 0, 0, 0));
      push_row(MODE_ADD, 32'h7FFF_FFFF, 0, 1, 1,
               rsp_of(32'h7FFF_FFFF, 1, 0, 1, 0, 1, 1));
      push_row(MODE_ADD, 32'h8000_0000, 31, 1, 1,
               rsp_of(32'h8000_0000, 1, 1, 1, 0, 2, 2));
      push_row(MODE_ADD, 32'h0, 0, 1, 1, rsp_of(0, 1, 2, 1, 0, 3, 3));
      push_row(MODE_ADD, 32'h0, 0, 1, 0, none);
      push_row(MODE_ADD, 32'hFFFF_FFFF, 0, 1, 1,
               rsp_of(32'hFFFF_FFFF, 1, 3, 1, 0, 4, 5));
      push_row(MODE_RANK, 32'h0, 0, 1, 0, none);
      push_row(MODE_RANK, 32'h0, 3, 1, 0, none);
      push_row(MODE_SLOT, 32'h0, 0, 1, 0, none);
      push_row(MODE_SLOT, 32'h0, 2, 1, 0, none);
      push_row(MODE_RANK, 32'h5555_5555, 4, 1, 1, rsp_of(0, 0, 0, 0, 0, 4, 5));
      push_row(MODE_SLOT, 32'h0, 31, 1, 1, rsp_of(0, 0, 0, 0, 0, 4, 5));
      push_row(MODE_RANK, 32'h0, 31, 1, 1, rsp_of(0, 0, 0, 0, 0, 4, 5));
      push_row(MODE_CLEAR, 32'h1234_5678, 31, 1, 1, rsp_of(0, 0, 0, 0, 0, 0, 0));
      push_row(MODE_RANK, 32'h0, 0, 1, 1, rsp_of(0, 0, 0, 0, 0, 0, 0));
      push_row(MODE_ADD, 32'd100, 0, ENTRIES, 0, none);
      push_row(MODE_ADD, 32'h0000_1000, 0, 1, 1,
               rsp_of(32'h0000_1000, 0, 0, 0, 1, ENTRIES, ENTRIES + 1));
      push_row(MODE_ADD, 32'd100, 0, 1, 0, none);
      push_row(MODE_ADD, 32'd131, 0, 1, 0, none);
      push_row(MODE_RANK, 32'h0, 31, 1, 0, none);
      push_row(MODE_SLOT, 32'h0, 31, 1, 0, none);
      push_row(MODE_RANK, 32'h0, 1, 1, 0, none);
      push_row(MODE_CLEAR, 32'h0, 0, 1, 1, rsp_of(0, 0, 0, 0, 0, 0, 0));

      gaps_on = 1'b1;
      foreach (plan[i]) begin
         for (k = 0; k < plan[i].reps; k++) begin
            rq          = plan[i].rq;
            rq.in_value = plan[i].rq.in_value + k;
            send_beat(rq, plan[i].has_rsp, plan[i].rsp);
            idle_gap();
         end
      end

      // Random part, in episodes. Each episode draws a pool of values and then
      // mostly adds from it, so counts climb and entries overtake each other;
      // some pools are larger than the table, so it fills and drops. Reads,
      // fresh values and the odd clear are mixed in.
      while (beats_sent < RANDOM_BEATS + plan.size()) begin
         pool_n  = ($urandom_range(0, 3) == 0) ? $urandom_range(ENTRIES - 2, ENTRIES + 8)
                                              : $urandom_range(1, 24);
         ep_len  = $urandom_range(20, 120);
         gaps_on = ($urandom_range(0, 3) != 0);
         for (i = 0; i < pool_n; i++) begin
            roll = $urandom_range(0, 9);
            if (roll < 2)
               pool[i] = $urandom_range(0, 15);
            else if (roll < 3)
               pool[i] = 32'h8000_0000 ^ $urandom_range(0, 3) ^ ((roll & 1) << 31);
            else
               pool[i] = $urandom;
         end
         for (k = 0; k < ep_len; k++) begin
            roll            = $urandom_range(0, 199);
            rq.in_value     = $urandom;
            rq.read_index   = 5'($urandom_range(0, $urandom_range(0, 31)));
            if (roll < 140) begin
               rq.mode = MODE_ADD;
               pick = $urandom_range(0, 1) ? $urandom_range(0, pool_n - 1)
                                           : $urandom_range(0, $urandom_range(0, pool_n - 1));
               rq.in_value = pool[pick];
            end else if (roll < 165) begin
               rq.mode = MODE_RANK;
            end else if (roll < 190) begin
               rq.mode = MODE_SLOT;
            end else if (roll < 198) begin
               rq.mode = MODE_ADD;
            end else begin
               rq.mode = MODE_CLEAR;
            end
            send_beat(rq, 1'b0, none);
            idle_gap();
         end
      end

      // Wind down: let every outstanding response arrive, then stay quiet for
      // DRAIN_CYCLES so that any stray beat is caught.
      start       <= 1'b0;
      row_has_rsp <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
